### src/trrg_pkg.sv
// Shared types, constants and codes for the terrain reflected radiation grid.
package trrg_pkg;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int NR_AROUND     = 2;
	localparam int ALB_ROWS      = 5;
	localparam int CTR_ROWS      = 3;
	localparam int SUM_W         = 20;
	localparam int CNT_W         = 5;
	localparam int MUL_W         = 17;
	localparam int PROD_W        = 2 * MUL_W;
	localparam int ALB_W         = 17;
	localparam int CTR_W         = 49;
	localparam logic [15:0] ONE_Q15 = 16'd32768;

	typedef enum logic [0:0] {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WRITE,
		S_CTR_RD,
		S_CTR_LAT,
		S_SUM,
		S_DRAIN,
		S_DIV_START,
		S_DIV_WAIT,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_MUL4,
		S_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quot;
	} div_rsp_t;

endpackage

### src/terrain_reflected_radiation_grid.sv
// Top level: line stores, window sequencer and result path of the radiation grid.
// Cells enter in raster order. Each accepted cell is transferred and then written to
// the albedo and center line stores. Then every result the input completes
// (up to nine) is built in turn: the center is read, each window cell (at most 25)
// is read through the single albedo read port and the read is drained, the window
// sum goes through the serial divider, four states use the shared multiplier, and
// the output register is loaded (waiting while the output stalls). A nodata result
// skips the window walk, divider and multiplier. An input that completes no window
// returns to idle; one at a frame corner may carry nine results.
// Writing grid_width or grid_height restarts the frame at cell (0,0).
module terrain_reflected_radiation_grid #(
	parameter int MAX_WIDTH = trrg_pkg::DEF_MAX_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  trrg_pkg::cfg_idx_t       cfg_index,
	input  logic [15:0]              cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [15:0]              albedo_in,
	input  logic                     albedo_ok,
	input  logic [15:0]              sky_view,
	input  logic                     sky_view_ok,
	input  logic [15:0]              direct_horiz,
	input  logic [15:0]              diffuse_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [15:0]              terrain_radiation,
	output logic [15:0]              diffuse_corrected,
	output logic                     result_ok,
	output logic [9:0]               out_col,
	output logic [15:0]              out_row,
	output logic                     last_of_run,
	output logic                     frame_done
);
	import trrg_pkg::*;

	localparam int CIW = $clog2(MAX_WIDTH);
	localparam int CW  = CIW + 1;
	localparam int AAW = $clog2(ALB_ROWS * MAX_WIDTH);
	localparam int CAW = $clog2(CTR_ROWS * MAX_WIDTH);

	function automatic logic [2:0] slot5(input logic [2:0] s, input logic [2:0] d);
		if (s >= d) return s - d;
		else return 3'(4'(s) + 4'(ALB_ROWS) - 4'(d));
	endfunction

	function automatic logic [1:0] slot3(input logic [1:0] s, input logic [1:0] d);
		if (s >= d) return s - d;
		else return 2'(3'(s) + 3'(CTR_ROWS) - 3'(d));
	endfunction

	state_t state_q, state_d;

	// configuration and raster position
	logic [10:0]   grid_width_q;
	logic [15:0]   grid_height_q;
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;
	logic [2:0]    rs5_q;
	logic [1:0]    rs3_q;
	logic [CW-1:0] w_eff;
	logic [15:0]   h_eff;

	// current item
	logic [15:0]   alb_q, svf_in_q, dir_in_q, dif_in_q;
	logic          aok_q, sok_in_q;
	logic [CW-1:0] cur_c_q;
	logic [15:0]   cur_r_q;
	logic [2:0]    cur_s5_q;
	logic [1:0]    cur_s3_q;

	// result loop and window loop
	logic [CW-1:0] clo_q, chi_q, c0_q, cc_q;
	logic [15:0]   rhi_q, r0_q, rr_q;
	logic [CW-1:0] wclo, wchi;
	logic [15:0]   wrlo, wrhi;

	// center data and arithmetic
	logic [15:0]       svf_q, dir_q, dif_q;
	logic              ok_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              rd_v_s1;
	logic [15:0]       mean_q;
	logic [15:0]       terr_q, dcor_q;

	// memories
	logic [ALB_W-1:0] alb_mem [ALB_ROWS*MAX_WIDTH];
	logic [CTR_W-1:0] ctr_mem [CTR_ROWS*MAX_WIDTH];
	logic [ALB_W-1:0] alb_rd_q;
	logic [CTR_W-1:0] ctr_rd_q;
	logic [AAW-1:0]   alb_waddr, alb_raddr;
	logic [CAW-1:0]   ctr_waddr, ctr_raddr;
	logic             mem_we;
	logic [2:0]       rd_s5;

	// shared units
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic [MUL_W-1:0]   mul_a, mul_b;
	logic [PROD_W-1:0]  prod;

	// output register
	logic        out_valid_q, load_out;
	logic [15:0] terr_o_q, dcor_o_q, row_o_q;
	logic [9:0]  col_o_q;
	logic        ok_o_q, last_o_q, frame_o_q;

	// position of the accepted cell
	logic          pos_reset, r_last, c_last, emit, res_last;
	logic [CW-1:0] c_now;
	logic [15:0]   r_now;
	logic [2:0]    s5_now;
	logic [1:0]    s3_now;

	// effective geometry
	always_comb begin
		if (grid_width_q == '0) w_eff = CW'(1);
		else if (int'(grid_width_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
		else w_eff = CW'(grid_width_q);
		h_eff = (grid_height_q == '0) ? 16'd1 : grid_height_q;
	end

	assign pos_reset = (col_q >= w_eff) || (row_q >= h_eff);
	assign c_now     = pos_reset ? '0 : col_q;
	assign r_now     = pos_reset ? '0 : row_q;
	assign s5_now    = pos_reset ? '0 : rs5_q;
	assign s3_now    = pos_reset ? '0 : rs3_q;

	assign r_last   = (cur_r_q == h_eff - 16'd1);
	assign c_last   = (cur_c_q == w_eff - CW'(1));
	assign emit     = (r_last || cur_r_q >= 16'(NR_AROUND)) &&
	                  (c_last || cur_c_q >= CW'(NR_AROUND));
	assign res_last = (c0_q == chi_q) && (r0_q == rhi_q);

	// window bounds of the current result cell, clipped at the edges
	always_comb begin
		wrlo = (r0_q >= 16'(NR_AROUND)) ? r0_q - 16'(NR_AROUND) : '0;
		wrhi = (17'(r0_q) + 17'(NR_AROUND) < 17'(h_eff)) ? r0_q + 16'(NR_AROUND)
		                                                  : h_eff - 16'd1;
		wclo = (c0_q >= CW'(NR_AROUND)) ? c0_q - CW'(NR_AROUND) : '0;
		wchi = (c0_q + CW'(NR_AROUND) < w_eff) ? c0_q + CW'(NR_AROUND) : w_eff - CW'(1);
	end

	// store addresses
	always_comb begin
		rd_s5     = slot5(cur_s5_q, 3'(cur_r_q - ((state_q == S_SUM) ? rr_q : r0_q)));
		alb_waddr = AAW'(cur_s5_q) * AAW'(MAX_WIDTH) + AAW'(cur_c_q[CIW-1:0]);
		ctr_waddr = CAW'(cur_s3_q) * CAW'(MAX_WIDTH) + CAW'(cur_c_q[CIW-1:0]);
		alb_raddr = AAW'(rd_s5) * AAW'(MAX_WIDTH) +
		            AAW'(((state_q == S_SUM) ? cc_q : c0_q) >> 0);
		ctr_raddr = CAW'(slot3(cur_s3_q, 2'(cur_r_q - r0_q))) * CAW'(MAX_WIDTH) +
		            CAW'(c0_q[CIW-1:0]);
	end

	// line stores
	always_ff @(posedge clk) begin
		if (mem_we) begin
			alb_mem[alb_waddr] <= {aok_q, alb_q};
			ctr_mem[ctr_waddr] <= {dif_in_q, dir_in_q, sok_in_q, svf_in_q};
		end
		alb_rd_q <= alb_mem[alb_raddr];
		ctr_rd_q <= ctr_mem[ctr_raddr];
	end

	trrg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	trrg_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:      if (in_valid) state_d = S_WRITE;
			S_WRITE:     state_d = emit ? S_CTR_RD : S_IDLE;
			S_CTR_RD:    state_d = S_CTR_LAT;
			S_CTR_LAT:   state_d = (ctr_rd_q[16] && alb_rd_q[16]) ? S_SUM : S_OUT;
			S_SUM:       if (cc_q == wchi && rr_q == wrhi) state_d = S_DRAIN;
			S_DRAIN:     state_d = S_DIV_START;
			S_DIV_START: state_d = S_DIV_WAIT;
			S_DIV_WAIT:  if (div_rsp.done) state_d = S_MUL1;
			S_MUL1:      state_d = S_MUL2;
			S_MUL2:      state_d = S_MUL3;
			S_MUL3:      state_d = S_MUL4;
			S_MUL4:      state_d = S_OUT;
			S_OUT:       if (load_out) state_d = res_last ? S_IDLE : S_CTR_RD;
			default:     state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready         = 1'b0;
		mem_we           = 1'b0;
		load_out         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = sum_q;
		div_req.divisor  = cnt_q;
		mul_a            = '0;
		mul_b            = '0;
		unique case (state_q)
			S_IDLE:      in_ready = 1'b1;
			S_WRITE:     mem_we = 1'b1;
			S_DIV_START: div_req.start = 1'b1;
			S_MUL1: begin
				mul_a = MUL_W'(mean_q);
				mul_b = MUL_W'(dir_q) + MUL_W'(dif_q);
			end
			S_MUL2: begin
				mul_a = prod[31:15];
				mul_b = MUL_W'(ONE_Q15) - MUL_W'(svf_q);
			end
			S_MUL3: begin
				mul_a = MUL_W'(dif_q);
				mul_b = MUL_W'(svf_q);
			end
			S_OUT:       load_out = !out_valid_q || out_ready;
			default:     ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			grid_width_q  <= 11'd1024;
			grid_height_q <= 16'd1024;
			col_q         <= '0;
			row_q         <= '0;
			rs5_q         <= '0;
			rs3_q         <= '0;
			rd_v_s1       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_v_s1     <= (state_q == S_SUM);
			out_valid_q <= load_out || (out_valid_q && !out_ready);
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_WIDTH:  grid_width_q  <= cfg_data[10:0];
					REG_GRID_HEIGHT: grid_height_q <= cfg_data;
					default:         ;
				endcase
				col_q <= '0;
				row_q <= '0;
				rs5_q <= '0;
				rs3_q <= '0;
			end else if (state_q == S_IDLE && in_valid) begin
				// step the raster position
				if (c_now + CW'(1) >= w_eff) begin
					col_q <= '0;
					if (17'(r_now) + 17'd1 >= 17'(h_eff)) begin
						row_q <= '0;
						rs5_q <= '0;
						rs3_q <= '0;
					end else begin
						row_q <= r_now + 16'd1;
						rs5_q <= (s5_now == 3'(ALB_ROWS - 1)) ? '0 : s5_now + 3'd1;
						rs3_q <= (s3_now == 2'(CTR_ROWS - 1)) ? '0 : s3_now + 2'd1;
					end
				end else begin
					col_q <= c_now + CW'(1);
					row_q <= r_now;
					rs5_q <= s5_now;
					rs3_q <= s3_now;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			alb_q    <= (albedo_in > ONE_Q15) ? ONE_Q15 : albedo_in;
			aok_q    <= albedo_ok;
			svf_in_q <= (sky_view > ONE_Q15) ? ONE_Q15 : sky_view;
			sok_in_q <= sky_view_ok;
			dir_in_q <= direct_horiz;
			dif_in_q <= diffuse_in;
			cur_c_q  <= c_now;
			cur_r_q  <= r_now;
			cur_s5_q <= s5_now;
			cur_s3_q <= s3_now;
		end
		// range of result cells completed by this input
		if (state_q == S_WRITE) begin
			rhi_q <= r_last ? cur_r_q : cur_r_q - 16'(NR_AROUND);
			clo_q <= (cur_c_q >= CW'(NR_AROUND)) ? cur_c_q - CW'(NR_AROUND) : '0;
			chi_q <= c_last ? cur_c_q : cur_c_q - CW'(NR_AROUND);
			r0_q  <= (cur_r_q >= 16'(NR_AROUND)) ? cur_r_q - 16'(NR_AROUND) : '0;
			c0_q  <= (cur_c_q >= CW'(NR_AROUND)) ? cur_c_q - CW'(NR_AROUND) : '0;
		end
		// latch center data and open the window walk
		if (state_q == S_CTR_LAT) begin
			svf_q  <= ctr_rd_q[15:0];
			dir_q  <= ctr_rd_q[32:17];
			dif_q  <= ctr_rd_q[48:33];
			ok_q   <= ctr_rd_q[16] && alb_rd_q[16];
			terr_q <= '0;
			dcor_q <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
			rr_q   <= wrlo;
			cc_q   <= wclo;
		end
		if (state_q == S_SUM) begin
			if (cc_q == wchi) begin
				cc_q <= wclo;
				rr_q <= rr_q + 16'd1;
			end else begin
				cc_q <= cc_q + CW'(1);
			end
		end
		// masked accumulation of read albedo
		if (rd_v_s1 && alb_rd_q[16]) begin
			sum_q <= sum_q + SUM_W'(alb_rd_q[15:0]);
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (state_q == S_DIV_WAIT && div_rsp.done)
			mean_q <= (cnt_q == '0) ? '0 : div_rsp.quot[15:0];
		if (state_q == S_MUL3)
			terr_q <= (prod[33:31] != '0) ? 16'hFFFF : prod[30:15];
		if (state_q == S_MUL4)
			dcor_q <= prod[30:15];
		// output register and result loop advance
		if (load_out) begin
			terr_o_q  <= terr_q;
			dcor_o_q  <= dcor_q;
			ok_o_q    <= ok_q && (state_q == S_OUT);
			col_o_q   <= 10'(c0_q);
			row_o_q   <= r0_q;
			last_o_q  <= res_last;
			frame_o_q <= (c0_q == w_eff - CW'(1)) && (r0_q == h_eff - 16'd1);
			if (c0_q == chi_q) begin
				c0_q <= clo_q;
				r0_q <= r0_q + 16'd1;
			end else begin
				c0_q <= c0_q + CW'(1);
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign terrain_radiation = terr_o_q;
	assign diffuse_corrected = dcor_o_q;
	assign result_ok         = ok_o_q;
	assign out_col           = col_o_q;
	assign out_row           = row_o_q;
	assign last_of_run       = last_o_q;
	assign frame_done        = frame_o_q;

	// nodata results carry zero values
	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_ok |-> terrain_radiation == '0 && diffuse_corrected == '0)
		else $error("nodata result with nonzero value");

	// the grid's last cell always closes its run
	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> last_of_run)
		else $error("frame_done without last_of_run");

	// one item at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while item in progress");

endmodule

### src/trrg_div.sv
// Restoring radix-2 divider: window sum over cell count, one quotient bit a cycle.
module trrg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  trrg_pkg::div_req_t req,
	output trrg_pkg::div_rsp_t rsp
);
	import trrg_pkg::*;

	localparam int IW = $clog2(SUM_W);

	logic [SUM_W-1:0] num_q;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W-1:0] den_q;
	logic [IW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W:0]   trial;

	// shift in the next dividend bit
	assign trial = {rem_q[CNT_W-1:0], num_q[SUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == IW'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath: quotient bits replace dividend bits from the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				num_q <= {num_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;

endmodule

### src/trrg_mul.sv
// Shared 17x17 multiplier with registered product.
module trrg_mul (
	input  logic                        clk,
	input  logic [trrg_pkg::MUL_W-1:0]  a,
	input  logic [trrg_pkg::MUL_W-1:0]  b,
	output logic [trrg_pkg::PROD_W-1:0] p
);
	import trrg_pkg::*;

	logic [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

### tb/terrain_reflected_radiation_grid_tb.sv
// Self-checking testbench for the terrain reflected radiation grid: random frames, checked result by result.
module terrain_reflected_radiation_grid_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import trrg_pkg::*;

	localparam int MAXW = 1024;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [15:0] alb;
		logic        alb_ok;
		logic [15:0] svf;
		logic        svf_ok;
		logic [15:0] dir;
		logic [15:0] dif;
	} cell_t;

	typedef struct {
		logic [15:0] terr;
		logic [15:0] dcor;
		logic        ok;
		logic [9:0]  col;
		logic [15:0] row;
		logic        last;
		logic        done;
	} rad_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = REG_GRID_WIDTH;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] albedo_in = '0, sky_view = '0, direct_horiz = '0, diffuse_in = '0;
	logic albedo_ok = 1'b0, sky_view_ok = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] terrain_radiation, diffuse_corrected, out_row;
	logic [9:0] out_col;
	logic result_ok, last_of_run, frame_done;

	terrain_reflected_radiation_grid DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [16:0] alb_store [ALB_ROWS*MAXW];
	logic [15:0] svf_store [CTR_ROWS*MAXW];
	logic        sok_store [CTR_ROWS*MAXW];
	logic [15:0] dir_store [CTR_ROWS*MAXW];
	logic [15:0] dif_store [CTR_ROWS*MAXW];
	int unsigned pos_col, pos_row, width_reg, height_reg;

	cell_t cells_pending[$];
	rad_t  rad_expected[$];
	int    errors = 0;
	longint cycles = 0;

	task automatic report(input string what, input int unsigned got, input int unsigned want);
		errors++;
		$display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	function automatic int unsigned cur_w();
		return width_reg < 1 ? 1 : (width_reg > MAXW ? MAXW : width_reg);
	endfunction

	function automatic int unsigned cur_h();
		return height_reg == 0 ? 1 : height_reg;
	endfunction

	// result of one cell from the stores
	function automatic rad_t cell_radiation(int unsigned c0, int unsigned r0,
			int unsigned w, int unsigned h);
		rad_t o;
		int unsigned ci, ai, rlo, rhi, clo, chi, sum, cnt, mean;
		logic [16:0] e;
		longint unsigned m, t;
		ci = (r0 % CTR_ROWS) * MAXW + c0;
		ai = (r0 % ALB_ROWS) * MAXW + c0;
		o.ok = sok_store[ci] && alb_store[ai][16];
		o.terr = '0;
		o.dcor = '0;
		if (o.ok) begin
			rlo = r0 >= 2 ? r0 - 2 : 0;
			rhi = (r0 + 2 < h) ? r0 + 2 : h - 1;
			clo = c0 >= 2 ? c0 - 2 : 0;
			chi = (c0 + 2 < w) ? c0 + 2 : w - 1;
			sum = 0;
			cnt = 0;
			for (int unsigned rr = rlo; rr <= rhi; rr++)
				for (int unsigned cc = clo; cc <= chi; cc++) begin
					e = alb_store[(rr % ALB_ROWS) * MAXW + cc];
					if (e[16]) begin
						sum += e[15:0];
						cnt++;
					end
				end
			mean = cnt != 0 ? sum / cnt : 0;
			m = (longint'(mean) * (longint'(dir_store[ci]) + dif_store[ci])) >> 15;
			t = (m * (32768 - longint'(svf_store[ci]))) >> 15;
			o.terr = t > 65535 ? 16'hFFFF : t[15:0];
			o.dcor = 16'((longint'(dif_store[ci]) * svf_store[ci]) >> 15);
		end
		o.col = c0[9:0];
		o.row = r0[15:0];
		o.last = 1'b0;
		o.done = (c0 == w - 1 && r0 == h - 1);
		return o;
	endfunction

	// store one accepted cell and queue the results it completes
	task automatic predict_radiation(input cell_t x);
		int unsigned w, h, c, r, rlo, rhi, clo, chi, n;
		logic [15:0] a, s;
		rad_t o;
		w = cur_w();
		h = cur_h();
		a = x.alb > 32768 ? 16'd32768 : x.alb;
		s = x.svf > 32768 ? 16'd32768 : x.svf;
		if (pos_col >= w || pos_row >= h) begin
			pos_col = 0;
			pos_row = 0;
		end
		c = pos_col;
		r = pos_row;
		alb_store[(r % ALB_ROWS) * MAXW + c] = {x.alb_ok, a};
		svf_store[(r % CTR_ROWS) * MAXW + c] = s;
		sok_store[(r % CTR_ROWS) * MAXW + c] = x.svf_ok;
		dir_store[(r % CTR_ROWS) * MAXW + c] = x.dir;
		dif_store[(r % CTR_ROWS) * MAXW + c] = x.dif;
		n = 0;
		if ((r == h - 1 || r >= 2) && (c == w - 1 || c >= 2)) begin
			rlo = r >= 2 ? r - 2 : 0;
			rhi = (r == h - 1) ? r : r - 2;
			clo = c >= 2 ? c - 2 : 0;
			chi = (c == w - 1) ? c : c - 2;
			for (int unsigned r0 = rlo; r0 <= rhi; r0++)
				for (int unsigned c0 = clo; c0 <= chi; c0++) begin
					o = cell_radiation(c0, r0, w, h);
					rad_expected.push_back(o);
					n++;
				end
			if (n > 0) rad_expected[$].last = 1'b1;
		end
		if (c + 1 >= w) begin
			pos_col = 0;
			pos_row = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			pos_col = c + 1;
		end
	endtask

	// input driver
	int in_gap = 0;
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predict_radiation(cells_pending.pop_front());
			in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
		end
		if (!in_valid || in_ready) begin
			if (in_gap > 0 || cells_pending.size() == 0 || !arst_n) begin
				if (in_gap > 0) in_gap--;
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				albedo_in <= cells_pending[0].alb;
				albedo_ok <= cells_pending[0].alb_ok;
				sky_view <= cells_pending[0].svf;
				sky_view_ok <= cells_pending[0].svf_ok;
				direct_horiz <= cells_pending[0].dir;
				diffuse_in <= cells_pending[0].dif;
			end
		end
	end

	// output monitor with random stalls
	int out_gap = 0;
	always @(posedge clk) begin
		rad_t e;
		cycles++;
		if (out_valid && out_ready) begin
			if (rad_expected.size() == 0) begin
				report("unexpected result, row", out_row, 0);
			end else begin
				e = rad_expected.pop_front();
				if (terrain_radiation !== e.terr) report("terrain_radiation", terrain_radiation, e.terr);
				if (diffuse_corrected !== e.dcor) report("diffuse_corrected", diffuse_corrected, e.dcor);
				if (result_ok !== e.ok) report("result_ok", result_ok, e.ok);
				if (out_col !== e.col) report("out_col", out_col, e.col);
				if (out_row !== e.row) report("out_row", out_row, e.row);
				if (last_of_run !== e.last) report("last_of_run", last_of_run, e.last);
				if (frame_done !== e.done) report("frame_done", frame_done, e.done);
			end
			out_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
		end
		if (out_gap > 0) begin
			out_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n;
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic cell_t rand_cell(input int unsigned bad_pct);
		cell_t x;
		x.alb = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768));
		x.svf = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768));
		x.alb_ok = $urandom_range(0, 99) >= bad_pct;
		x.svf_ok = $urandom_range(0, 99) >= bad_pct;
		x.dir = 16'($urandom);
		x.dif = 16'($urandom);
		return x;
	endfunction

	// wait for idle, then write a register
	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		wait (cells_pending.size() == 0 && !in_valid && rad_expected.size() == 0);
		repeat (80) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_GRID_WIDTH) width_reg = val[10:0];
		else height_reg = val;
		pos_col = 0;
		pos_row = 0;
	endtask

	task automatic run_frame(input int unsigned w, input int unsigned h,
			input int unsigned ncells, input int unsigned bad_pct);
		write_reg(REG_GRID_WIDTH, 16'(w));
		write_reg(REG_GRID_HEIGHT, 16'(h));
		repeat (ncells) cells_pending.push_back(rand_cell(bad_pct));
	endtask

	initial begin
		cell_t x;
		width_reg = 1024;
		height_reg = 1024;
		pos_col = 0;
		pos_row = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: 3x3 grid with field extremes, then a 1x1 grid fed two random cells
		write_reg(REG_GRID_WIDTH, 16'd3);
		write_reg(REG_GRID_HEIGHT, 16'd3);
		for (int i = 0; i < 9; i++) begin
			x.alb = (i == 0) ? 16'hFFFF : (i == 1 ? 16'd0 : 16'd32768);
			x.svf = (i == 2) ? 16'hFFFF : (i == 3 ? 16'd32768 : 16'd0);
			x.alb_ok = (i != 4);
			x.svf_ok = (i != 5);
			x.dir = (i == 1) ? 16'd0 : 16'hFFFF;
			x.dif = (i == 6) ? 16'd0 : 16'hFFFF;
			cells_pending.push_back(x);
		end
		run_frame(1, 1, 2, 10);
		run_frame(5, 2, 10, 20);
		// width register above the limit clamps to the maximum
		run_frame(2047, 3, 40, 10);
		run_frame(2, 4, 8, 30);
		run_frame(1, 6, 6, 10);
		// random frames with small widths
		for (int f = 0; f < 6; f++)
			run_frame($urandom_range(1, 9), $urandom_range(1, 7), 15, 15);
		run_frame(0, 0, 3, 10);
		run_frame(7, 65535, 30, 10);
		wait (cells_pending.size() == 0 && !in_valid && rad_expected.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && rad_expected.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

### sim.f
src/trrg_pkg.sv
src/trrg_div.sv
src/trrg_mul.sv
src/terrain_reflected_radiation_grid.sv
tb/terrain_reflected_radiation_grid_tb.sv
